### rtl/core/ufd_pkg.sv
package ufd_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW = $clog2(QDepth);
  localparam int unsigned QCntW = $clog2(QDepth + 1);

  typedef struct packed {
    logic [7:0] byte_in;
    logic       stream_end;
  } in_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic        is_error;
    logic        run_last;
  } out_t;

  // one byte's worth of results: n_err errors, then an optional code point
  typedef struct packed {
    logic [2:0]  n_err;
    logic        has_val;
    logic [20:0] cp;
  } job_t;

endpackage

### rtl/core/ufd_front.sv
module ufd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  input  ufd_pkg::in_t  in_data,
  output logic          in_full,
  input  logic          q_full,
  output logic          job_push,
  output ufd_pkg::job_t job
);

  logic [7:0] lead_r, lead_nxt;
  logic [1:0] exp_r, exp_nxt;
  logic [1:0] taken_r, taken_nxt;
  logic [7:0] t0_r, t0_nxt;
  logic [7:0] t1_r, t1_nxt;
  logic       accept;
  logic       fresh;
  logic [7:0] b;
  logic       is_cont;
  logic [20:0] asm_cp;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;
  assign b       = in_data.byte_in;
  assign is_cont = (b[7:6] == 2'b10);

  always_comb begin
    unique case (exp_r)
      2'd1:    asm_cp = {10'd0, lead_r[4:0], b[5:0]};
      2'd2:    asm_cp = {5'd0, lead_r[3:0], t0_r[5:0], b[5:0]};
      default: asm_cp = {lead_r[2:0], t0_r[5:0], t1_r[5:0], b[5:0]};
    endcase
  end

  always_comb begin
    lead_nxt  = lead_r;
    exp_nxt   = exp_r;
    taken_nxt = taken_r;
    t0_nxt    = t0_r;
    t1_nxt    = t1_r;
    job       = '0;
    fresh     = 1'b0;
    if (exp_r != 2'd0) begin
      if (is_cont) begin
        if (({1'b0, taken_r} + 3'd1) >= {1'b0, exp_r}) begin
          job.has_val = 1'b1;
          job.cp      = asm_cp;
          exp_nxt     = 2'd0;
          taken_nxt   = 2'd0;
        end else begin
          if (taken_r == 2'd0) begin
            t0_nxt = b;
          end else begin
            t1_nxt = b;
          end
          taken_nxt = taken_r + 2'd1;
        end
      end else begin
        // drop the open sequence: lead plus each taken byte
        job.n_err = 3'd1 + {1'b0, taken_r};
        exp_nxt   = 2'd0;
        taken_nxt = 2'd0;
        fresh     = 1'b1;
      end
    end else begin
      fresh = 1'b1;
    end
    if (fresh) begin
      if (!b[7]) begin
        job.has_val = 1'b1;
        job.cp      = {13'd0, b};
      end else if (!b[6]) begin
        job.n_err = job.n_err + 3'd1;
      end else begin
        lead_nxt  = b;
        taken_nxt = 2'd0;
        if (!b[5]) begin
          exp_nxt = 2'd1;
        end else if (!b[4]) begin
          exp_nxt = 2'd2;
        end else begin
          exp_nxt = 2'd3;
        end
      end
    end
    if (in_data.stream_end && exp_nxt != 2'd0) begin
      job.n_err = job.n_err + 3'd1 + {1'b0, taken_nxt};
      exp_nxt   = 2'd0;
      taken_nxt = 2'd0;
    end
  end

  assign job_push = accept && (job.has_val || job.n_err != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r   <= 2'd0;
      taken_r <= 2'd0;
    end else if (accept) begin
      exp_r   <= exp_nxt;
      taken_r <= taken_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lead_r <= lead_nxt;
      t0_r   <= t0_nxt;
      t1_r   <= t1_nxt;
    end
  end

endmodule

### rtl/core/ufd_jobq.sv
module ufd_jobq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ufd_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output ufd_pkg::job_t head,
  output logic          empty
);

  ufd_pkg::job_t mem [ufd_pkg::QDepth];
  logic [ufd_pkg::QPtrW-1:0] wr_r, rd_r;
  logic [ufd_pkg::QCntW-1:0] cnt_r;
  logic do_push, do_pop;

  assign full    = (cnt_r == ufd_pkg::QCntW'(ufd_pkg::QDepth));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= rd_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

### rtl/core/ufd_back.sv
module ufd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  ufd_pkg::job_t head,
  input  logic          q_empty,
  output logic          q_pop,
  output logic          out_empty,
  input  logic          out_pop,
  output ufd_pkg::out_t out_data
);

  logic [1:0]    done_r;
  logic          out_valid_r;
  ufd_pkg::out_t out_r;
  logic [2:0]    total;
  logic          emit;
  logic          emit_err;
  logic          last;

  assign total    = head.n_err + {2'b00, head.has_val};
  assign emit_err = ({1'b0, done_r} < head.n_err);
  assign last     = (({1'b0, done_r} + 3'd1) == total);
  assign emit     = !q_empty && (!out_valid_r || out_pop);
  assign q_pop    = emit && last;

  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
        done_r      <= last ? 2'd0 : done_r + 2'd1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r.code_point <= emit_err ? 21'd0 : head.cp;
      out_r.is_error   <= emit_err;
      out_r.run_last   <= last;
    end
  end

endmodule

### rtl/core/utf8_stream_decoder.sv
// Byte-serial UTF-8 decoder with queue-style ports on both sides.
// Input: drive in_data (byte_in, stream_end) with in_push; a beat is taken
// at a clock edge where in_push is high and in_full is low.
// Output: while out_empty is low, out_data holds the oldest result
// (code_point, is_error, run_last); out_pop takes it.
// A byte gives zero to four results; run_last marks the last one of a byte.
// A byte that only opens or extends a sequence gives no result.
// A byte's results pass through the job queue and then the output register.
// Throughput: one byte per cycle while each byte gives at most one result
// and the receiver keeps up; a byte giving several results holds the output
// until each is emitted in turn, and the four-entry job queue between decoder
// front and result expander absorbs such bursts before in_full rises.
// When the receiver stalls, the output beat holds, the job queue fills and
// in_full rises; no beat is lost.
// Reset (rst_n low, synchronous) closes any open sequence and empties the
// queue and the output register; the block is ready the cycle after.
module utf8_stream_decoder (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  ufd_pkg::in_t  in_data,
  output logic          out_empty,
  input  logic          out_pop,
  output ufd_pkg::out_t out_data
);

  ufd_pkg::job_t job_w;
  ufd_pkg::job_t head_w;
  logic          job_push;
  logic          q_full;
  logic          q_empty;
  logic          q_pop;

  ufd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .q_full   (q_full),
    .job_push (job_push),
    .job      (job_w)
  );

  ufd_jobq u_jobq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_w),
    .full      (q_full),
    .pop       (q_pop),
    .head      (head_w),
    .empty     (q_empty)
  );

  ufd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head_w),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int CycleLimit = 200000;
  localparam int RandomBytes = 320;
  localparam logic [7:0] ContLo = 8'h80;
  localparam logic [7:0] ContHi = 8'hBF;
  localparam logic [7:0] Lead2Lo = 8'hC0;
  localparam logic [7:0] Lead2Hi = 8'hDF;
  localparam logic [7:0] Lead3Lo = 8'hE0;
  localparam logic [7:0] Lead3Hi = 8'hEF;
  localparam logic [7:0] Lead4Lo = 8'hF0;
  localparam logic [7:0] AsciiHi = 8'h7F;

  class utf8_decode_sb;
    logic [7:0]    lead;
    logic [1:0]    need;
    logic [1:0]    got_cnt;
    logic [7:0]    held [2];
    ufd_pkg::out_t burst [$];
    ufd_pkg::out_t pending_cps [$];
    int            errors;

    function new();
      clear_seq();
      errors = 0;
    endfunction

    function void clear_seq();
      lead = '0;
      need = '0;
      got_cnt = '0;
      held[0] = '0;
      held[1] = '0;
    endfunction

    function void add_cp(logic [20:0] cp, bit err);
      ufd_pkg::out_t r;
      r.code_point = err ? 21'd0 : cp;
      r.is_error = err;
      r.run_last = 1'b0;
      burst.push_back(r);
    endfunction

    function void drop_seq();
      add_cp('0, 1'b1);
      for (int i = 0; i < int'(got_cnt) && i < 2; i++) add_cp('0, 1'b1);
      clear_seq();
    endfunction

    function void open_lead(logic [7:0] b);
      if (b <= AsciiHi) begin
        add_cp({13'd0, b}, 1'b0);
      end else if (b <= ContHi) begin
        add_cp('0, 1'b1);
      end else begin
        lead = b;
        got_cnt = '0;
        if (b <= Lead2Hi) need = 2'd1;
        else if (b <= Lead3Hi) need = 2'd2;
        else need = 2'd3;
      end
    endfunction

    function logic [20:0] assemble(logic [7:0] z);
      unique case (need)
        2'd1: return {10'd0, lead[4:0], z[5:0]};
        2'd2: return {5'd0, lead[3:0], held[0][5:0], z[5:0]};
        default: return {lead[2:0], held[0][5:0], held[1][5:0], z[5:0]};
      endcase
    endfunction

    // predict the results of one accepted beat
    function void take_byte(ufd_pkg::in_t it);
      burst.delete();
      if (need != 0) begin
        if (it.byte_in >= ContLo && it.byte_in <= ContHi) begin
          if (int'(got_cnt) + 1 >= int'(need)) begin
            add_cp(assemble(it.byte_in), 1'b0);
            clear_seq();
          end else begin
            if (got_cnt < 2) held[got_cnt[0]] = it.byte_in;
            got_cnt = got_cnt + 2'd1;
          end
        end else begin
          drop_seq();
          open_lead(it.byte_in);
        end
      end else begin
        open_lead(it.byte_in);
      end
      if (it.stream_end && need != 0) drop_seq();
      if (burst.size() > 0) burst[burst.size() - 1].run_last = 1'b1;
      foreach (burst[i]) pending_cps.push_back(burst[i]);
    endfunction

    function void match_result(ufd_pkg::out_t got);
      ufd_pkg::out_t exp_r;
      if (pending_cps.size() == 0) begin
        $display("%0t: unexpected result cp=%h err=%b last=%b", $time,
                 got.code_point, got.is_error, got.run_last);
        errors++;
        return;
      end
      exp_r = pending_cps.pop_front();
      if (got.code_point !== exp_r.code_point) begin
        $display("%0t: code_point expected %h actual %h", $time,
                 exp_r.code_point, got.code_point);
        errors++;
      end
      if (got.is_error !== exp_r.is_error) begin
        $display("%0t: is_error expected %b actual %b", $time,
                 exp_r.is_error, got.is_error);
        errors++;
      end
      if (got.run_last !== exp_r.run_last) begin
        $display("%0t: run_last expected %b actual %b", $time,
                 exp_r.run_last, got.run_last);
        errors++;
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_push = 1'b0;
  logic          in_full;
  ufd_pkg::in_t  in_data = '0;
  logic          out_empty;
  logic          out_pop = 1'b0;
  ufd_pkg::out_t out_data;

  utf8_decode_sb sb = new();
  int   cycles = 0;
  int   bytes_sent = 0;
  bit   tx_fast = 1'b0;
  bit   rx_fast = 1'b0;

  utf8_stream_decoder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic push_byte(logic [7:0] b, bit last);
    int           gap;
    ufd_pkg::in_t it;
    it.byte_in = b;
    it.stream_end = last;
    if (bytes_sent % 30 == 0) tx_fast = ($urandom_range(0, 3) == 0);
    gap = tx_fast ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_full);
    sb.take_byte(it);
    bytes_sent++;
  endtask

  function automatic logic [7:0] lead_for(int len);
    unique case (len)
      1: return 8'($urandom_range(0, AsciiHi));
      2: return 8'($urandom_range(Lead2Lo, Lead2Hi));
      3: return 8'($urandom_range(Lead3Lo, Lead3Hi));
      default: return 8'($urandom_range(Lead4Lo, 8'hFF));
    endcase
  endfunction

  function automatic logic [7:0] cont_byte();
    return 8'($urandom_range(ContLo, ContHi));
  endfunction

  task automatic send_random_seq();
    logic [7:0] seq [$];
    int kind;
    int len;
    kind = $urandom_range(0, 9);
    len = $urandom_range(1, 4);
    if (kind <= 5) begin
      seq.push_back(lead_for(len));
      repeat (len - 1) seq.push_back(cont_byte());
    end else if (kind == 6 || kind == 9) begin
      len = $urandom_range(2, 4);
      seq.push_back(lead_for(len));
      repeat ($urandom_range(0, len - 2)) seq.push_back(cont_byte());
      if (kind == 9) begin
        seq.push_back($urandom_range(0, 1) ? lead_for(1) : lead_for($urandom_range(2, 4)));
      end
    end else if (kind == 7) begin
      seq.push_back(8'($urandom_range(0, 255)));
    end else begin
      seq.push_back(cont_byte());
    end
    foreach (seq[i]) push_byte(seq[i], $urandom_range(0, 24) == 0);
  endtask

  initial begin
    int pops;
    pops = 0;
    @(posedge rst_n);
    forever begin
      int stall;
      if (pops % 30 == 0) rx_fast = ($urandom_range(0, 3) == 0);
      stall = rx_fast ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      sb.match_result(out_data);
      pops++;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    push_byte(8'h00, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hC2, 1'b0);
    push_byte(8'hA9, 1'b0);
    push_byte(8'hE2, 1'b0);
    push_byte(8'h82, 1'b0);
    push_byte(8'hAC, 1'b0);
    push_byte(8'hF0, 1'b0);
    push_byte(8'h9F, 1'b0);
    push_byte(8'h98, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hE2, 1'b0);
    push_byte(8'hC3, 1'b0);
    push_byte(8'hA9, 1'b0);
    push_byte(8'hF0, 1'b0);
    push_byte(8'h90, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h41, 1'b0);
    push_byte(8'hE2, 1'b1);
    push_byte(8'hF4, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h80, 1'b1);
    push_byte(8'h41, 1'b1);

    // hold until the decoder has drained
    in_push <= 1'b0;
    while (sb.pending_cps.size() != 0) @(posedge clk);

    bytes_sent = 0;
    while (bytes_sent < RandomBytes) send_random_seq();
    in_push <= 1'b0;

    while (sb.pending_cps.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### utf8_stream_decoder.f
rtl/core/ufd_pkg.sv
rtl/core/ufd_front.sv
rtl/core/ufd_jobq.sv
rtl/core/ufd_back.sv
rtl/core/utf8_stream_decoder.sv
verif/tb.sv
